// ----- rtl/dirty_rectangle_tracker_defines.svh -----
// ----------------------------------------------------------------------------
// dirty rectangle tracker assertion macros
// shared property wrappers for the checker, clocked on clk_i, off in reset
// ----------------------------------------------------------------------------
`ifndef DIRTY_RECTANGLE_TRACKER_DEFINES_SVH
`define DIRTY_RECTANGLE_TRACKER_DEFINES_SVH

// same-cycle implication
`define DRT_ASSERT_NOW(lbl, pre, post, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (pre) |-> (post)) \
    else $error(msg);

// next-cycle implication
`define DRT_ASSERT_NEXT(lbl, pre, post, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (pre) |=> (post)) \
    else $error(msg);

`endif

// ----- rtl/drt_pkg.sv -----
// ----------------------------------------------------------------------------
// drt_pkg
// item types, operation and status codes, controller/datapath interface
// ----------------------------------------------------------------------------
package drt_pkg;

  localparam logic [2:0] OP_WORD = 3'd0;
  localparam logic [2:0] OP_POL  = 3'd1;
  localparam logic [2:0] OP_TAKE = 3'd2;
  localparam logic [2:0] OP_LOAD = 3'd3;
  localparam logic [2:0] OP_INIT = 3'd4;

  localparam logic [1:0] ST_OK   = 2'd0;
  localparam logic [1:0] ST_FAIL = 2'd1;
  localparam logic [1:0] ST_BAD  = 2'd2;

  localparam logic [2:0] RES_OK        = 3'd0;
  localparam logic [2:0] RES_FAIL      = 3'd1;
  localparam logic [2:0] RES_BAD       = 3'd2;
  localparam logic [2:0] RES_FULL      = 3'd3;
  localparam logic [2:0] RES_EMPTY     = 3'd4;
  localparam logic [2:0] RES_RECT      = 3'd5;
  localparam logic [2:0] RES_RECT_LAST = 3'd6;

  localparam int unsigned MARK_W = 6;

  typedef struct packed {
    logic [2:0]  op;
    logic [13:0] word_index;
    logic [31:0] word_value;
    logic        polarity_bit;
  } drt_in_t;

  typedef struct packed {
    logic [1:0]  status;
    logic        rect_valid;
    logic [9:0]  rect_x;
    logic [8:0]  rect_y;
    logic [10:0] rect_width;
    logic [9:0]  rect_height;
    logic [14:0] rect_words;
    logic        rect_last;
    logic        full_flag;
    logic [63:0] generation;
    logic        failed_flag;
  } drt_out_t;

  typedef struct packed {
    logic       take_item;
    logic       clr_step;
    logic       mir_wr;
    logic       mir_rd;
    logic       div_calc;
    logic       rowcol_ld;
    logic       gen_inc;
    logic       set_fail;
    logic       pol_ld;
    logic       full_set;
    logic       full_clr;
    logic       cursor_clr;
    logic       cursor_ld;
    logic       scan_from_cursor;
    logic       scan_inc;
    logic       row_rd_scan;
    logic       row_rd_obs;
    logic       row_wr_mark;
    logic       mark_ld;
    logic       end_ld;
    logic       res_ld;
    logic [2:0] res_kind;
    logic       out_ld;
  } drt_cmd_t;

  typedef struct packed {
    logic [2:0] op;
    logic       failed;
    logic       full;
    logic       gen_max;
    logic       in_range;
    logic       pol_diff;
    logic       mir_diff;
    logic       row_dirty;
    logic       row_match;
    logic       bad_range;
    logic       scan_end;
    logic       clr_last;
    logic       out_free;
  } drt_sts_t;

endpackage

// ----- rtl/drt_ram.sv -----
// ----------------------------------------------------------------------------
// drt_ram
// simple dual-port ram, one write and one registered read port
// ----------------------------------------------------------------------------
module drt_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 16,
  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ----- rtl/drt_ctrl.sv -----
// ----------------------------------------------------------------------------
// drt_ctrl
// sequencing state machine for observe, take, reinit and mark clearing
// ----------------------------------------------------------------------------
module drt_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  drt_pkg::drt_sts_t sts_i,
  output drt_pkg::drt_cmd_t cmd_o
);
  import drt_pkg::*;

  localparam logic [3:0] S_CLR     = 4'd0;
  localparam logic [3:0] S_IDLE    = 4'd1;
  localparam logic [3:0] S_DISP    = 4'd2;
  localparam logic [3:0] S_OBS_A   = 4'd3;
  localparam logic [3:0] S_OBS_B   = 4'd4;
  localparam logic [3:0] S_OBS_C   = 4'd5;
  localparam logic [3:0] S_SCAN_RD = 4'd6;
  localparam logic [3:0] S_SCAN_CK = 4'd7;
  localparam logic [3:0] S_MRG_RD  = 4'd8;
  localparam logic [3:0] S_MRG_CK  = 4'd9;
  localparam logic [3:0] S_NXT_RD  = 4'd10;
  localparam logic [3:0] S_NXT_CK  = 4'd11;
  localparam logic [3:0] S_FIN     = 4'd12;

  logic [3:0] state_q, state_d;
  logic       ret_q, ret_d;
  drt_cmd_t   cmd;

  always_comb begin
    state_d = state_q;
    ret_d   = ret_q;
    cmd     = '0;
    case (state_q)
      S_CLR: begin
        cmd.clr_step = 1'b1;
        if (sts_i.clr_last) begin
          state_d = ret_q ? S_FIN : S_IDLE;
        end
      end
      S_IDLE: begin
        if (in_valid_i) begin
          cmd.take_item = 1'b1;
          state_d       = S_DISP;
        end
      end
      S_DISP: begin
        cmd.res_ld   = 1'b1;
        cmd.res_kind = RES_OK;
        state_d      = S_FIN;
        if (sts_i.op == OP_LOAD) begin
          cmd.mir_wr = sts_i.in_range;
        end else if (sts_i.op > OP_INIT) begin
          // unknown op, nothing to do
        end else if (sts_i.failed) begin
          cmd.res_kind = RES_FAIL;
        end else begin
          case (sts_i.op)
            OP_WORD: begin
              if (sts_i.in_range) begin
                cmd.res_ld   = 1'b0;
                cmd.mir_rd   = 1'b1;
                cmd.div_calc = 1'b1;
                state_d      = S_OBS_A;
              end
            end
            OP_POL: begin
              if (sts_i.pol_diff) begin
                if (sts_i.gen_max) begin
                  cmd.set_fail = 1'b1;
                  cmd.res_kind = RES_FAIL;
                end else begin
                  cmd.gen_inc  = 1'b1;
                  cmd.pol_ld   = 1'b1;
                  cmd.full_set = 1'b1;
                  ret_d        = 1'b1;
                  state_d      = S_CLR;
                end
              end
            end
            OP_INIT: begin
              if (sts_i.gen_max) begin
                cmd.set_fail = 1'b1;
                cmd.res_kind = RES_FAIL;
              end else begin
                cmd.gen_inc    = 1'b1;
                cmd.pol_ld     = 1'b1;
                cmd.full_set   = 1'b1;
                cmd.cursor_clr = 1'b1;
                ret_d          = 1'b1;
                state_d        = S_CLR;
              end
            end
            OP_TAKE: begin
              if (sts_i.full) begin
                cmd.res_kind   = RES_FULL;
                cmd.full_clr   = 1'b1;
                cmd.cursor_clr = 1'b1;
                ret_d          = 1'b1;
                state_d        = S_CLR;
              end else begin
                cmd.res_ld           = 1'b0;
                cmd.scan_from_cursor = 1'b1;
                state_d              = S_SCAN_RD;
              end
            end
            default: begin
            end
          endcase
        end
      end
      S_OBS_A: begin
        cmd.rowcol_ld = 1'b1;
        state_d       = S_OBS_B;
      end
      S_OBS_B: begin
        cmd.res_ld   = 1'b1;
        cmd.res_kind = RES_OK;
        state_d      = S_FIN;
        if (sts_i.mir_diff) begin
          if (sts_i.gen_max) begin
            cmd.set_fail = 1'b1;
            cmd.res_kind = RES_FAIL;
          end else begin
            cmd.res_ld     = 1'b0;
            cmd.mir_wr     = 1'b1;
            cmd.gen_inc    = 1'b1;
            cmd.row_rd_obs = 1'b1;
            state_d        = S_OBS_C;
          end
        end
      end
      S_OBS_C: begin
        cmd.row_wr_mark = 1'b1;
        cmd.res_ld      = 1'b1;
        cmd.res_kind    = RES_OK;
        state_d         = S_FIN;
      end
      S_SCAN_RD: begin
        if (sts_i.scan_end) begin
          cmd.res_ld     = 1'b1;
          cmd.res_kind   = RES_EMPTY;
          cmd.cursor_clr = 1'b1;
          ret_d          = 1'b1;
          state_d        = S_CLR;
        end else begin
          cmd.row_rd_scan = 1'b1;
          state_d         = S_SCAN_CK;
        end
      end
      S_SCAN_CK: begin
        if (!sts_i.row_dirty) begin
          cmd.scan_inc = 1'b1;
          state_d      = S_SCAN_RD;
        end else if (sts_i.bad_range) begin
          cmd.res_ld     = 1'b1;
          cmd.res_kind   = RES_BAD;
          cmd.cursor_clr = 1'b1;
          state_d        = S_FIN;
        end else begin
          cmd.mark_ld  = 1'b1;
          cmd.scan_inc = 1'b1;
          state_d      = S_MRG_RD;
        end
      end
      S_MRG_RD: begin
        if (sts_i.scan_end) begin
          cmd.end_ld = 1'b1;
          state_d    = S_NXT_RD;
        end else begin
          cmd.row_rd_scan = 1'b1;
          state_d         = S_MRG_CK;
        end
      end
      S_MRG_CK: begin
        if (sts_i.row_dirty && sts_i.row_match) begin
          cmd.scan_inc = 1'b1;
          state_d      = S_MRG_RD;
        end else begin
          cmd.end_ld = 1'b1;
          state_d    = S_NXT_CK;
        end
      end
      S_NXT_RD: begin
        if (sts_i.scan_end) begin
          cmd.res_ld     = 1'b1;
          cmd.res_kind   = RES_RECT_LAST;
          cmd.cursor_clr = 1'b1;
          ret_d          = 1'b1;
          state_d        = S_CLR;
        end else begin
          cmd.row_rd_scan = 1'b1;
          state_d         = S_NXT_CK;
        end
      end
      S_NXT_CK: begin
        if (sts_i.row_dirty) begin
          cmd.res_ld    = 1'b1;
          cmd.res_kind  = RES_RECT;
          cmd.cursor_ld = 1'b1;
          state_d       = S_FIN;
        end else begin
          cmd.scan_inc = 1'b1;
          state_d      = S_NXT_RD;
        end
      end
      S_FIN: begin
        if (sts_i.out_free) begin
          cmd.out_ld = 1'b1;
          ret_d      = 1'b0;
          state_d    = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_CLR;
      ret_q   <= 1'b0;
    end else begin
      state_q <= state_d;
      ret_q   <= ret_d;
    end
  end

  assign in_ready_o = (state_q == S_IDLE);
  assign cmd_o      = cmd;

endmodule

// ----- rtl/drt_dp.sv -----
// ----------------------------------------------------------------------------
// drt_dp
// mirror and row mark memories, generation, flags, scan and result registers
// ----------------------------------------------------------------------------
module drt_dp #(
  parameter int unsigned ROWS      = 512,
  parameter int unsigned ROW_WORDS = 32
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  drt_pkg::drt_in_t  in_data_i,
  input  logic              out_ready_i,
  output logic              out_valid_o,
  output drt_pkg::drt_out_t out_data_o,
  input  drt_pkg::drt_cmd_t cmd_i,
  output drt_pkg::drt_sts_t sts_o
);
  import drt_pkg::*;

  localparam int unsigned SCREEN = ROWS * ROW_WORDS;
  localparam int unsigned MDEPTH = (SCREEN > 16384) ? 16384 : SCREEN;
  localparam int unsigned MAW    = (MDEPTH > 1) ? $clog2(MDEPTH) : 1;
  localparam int unsigned RAW    = (ROWS > 1) ? $clog2(ROWS) : 1;
  localparam int unsigned SW     = $clog2(ROWS + 1);
  localparam int unsigned RSH    = 20;
  localparam int unsigned RECIP  = (1 << RSH) / ROW_WORDS;
  localparam int unsigned FULL_W = (ROW_WORDS * 32) % 2048;
  localparam int unsigned FULL_H = ROWS % 1024;
  localparam int unsigned FULL_N = SCREEN % 32768;

  drt_in_t            item_q;
  logic [63:0]        gen_q;
  logic               pol_q, full_q, failed_q;
  logic [SW-1:0]      cursor_q, scan_q, row_q, end_q;
  logic [RAW-1:0]     clr_q, obs_row_q;
  logic [4:0]         col_q;
  logic [34:0]        prod_q;
  logic [MARK_W-1:0]  mn_q, mx_q;
  drt_out_t           res_q, res_d, out_q, out_d;
  logic               out_valid_q;

  logic [31:0]        mir_rdata;
  logic [2*MARK_W-1:0] row_rdata, row_wdata;
  logic [MARK_W-1:0]  rd_first, rd_end, new_first, new_end;
  logic               row_we, row_re;
  logic [RAW-1:0]     row_waddr, row_raddr;

  // division by row width through a reciprocal with one correction step
  logic [13:0] q0, qrw, rem, q_fix, rem_fix;
  logic [19:0] qrw_full;

  assign q0       = prod_q[RSH+13:RSH];
  assign qrw_full = 20'(q0) * 20'(ROW_WORDS);
  assign qrw      = qrw_full[13:0];
  assign rem      = item_q.word_index - qrw;
  assign q_fix    = (rem >= 14'(ROW_WORDS)) ? q0 + 14'd1 : q0;
  assign rem_fix  = (rem >= 14'(ROW_WORDS)) ? rem - 14'(ROW_WORDS) : rem;

  assign rd_first = row_rdata[2*MARK_W-1:MARK_W];
  assign rd_end   = row_rdata[MARK_W-1:0];

  always_comb begin
    new_first = rd_first;
    if (rd_end == '0 || MARK_W'(col_q) < rd_first) begin
      new_first = MARK_W'(col_q);
    end
    new_end = rd_end;
    if (MARK_W'(col_q) + MARK_W'(1) > rd_end) begin
      new_end = MARK_W'(col_q) + MARK_W'(1);
    end
  end

  assign row_we    = cmd_i.clr_step | cmd_i.row_wr_mark;
  assign row_waddr = cmd_i.clr_step ? clr_q : obs_row_q;
  assign row_wdata = cmd_i.clr_step ? '0 : {new_first, new_end};
  assign row_re    = cmd_i.row_rd_scan | cmd_i.row_rd_obs;
  assign row_raddr = cmd_i.row_rd_obs ? obs_row_q : scan_q[RAW-1:0];

  drt_ram #(.WIDTH(32), .DEPTH(MDEPTH)) u_mirror (
    .clk_i   (clk_i),
    .we_i    (cmd_i.mir_wr),
    .waddr_i (item_q.word_index[MAW-1:0]),
    .wdata_i (item_q.word_value),
    .re_i    (cmd_i.mir_rd),
    .raddr_i (item_q.word_index[MAW-1:0]),
    .rdata_o (mir_rdata)
  );

  drt_ram #(.WIDTH(2*MARK_W), .DEPTH(ROWS)) u_marks (
    .clk_i   (clk_i),
    .we_i    (row_we),
    .waddr_i (row_waddr),
    .wdata_i (row_wdata),
    .re_i    (row_re),
    .raddr_i (row_raddr),
    .rdata_o (row_rdata)
  );

  // result fields of the current item
  logic [MARK_W-1:0] span;
  logic [10:0]       rh;
  logic [16:0]       nwords;

  assign span   = mx_q - mn_q;
  assign rh     = 11'(end_q) - 11'(row_q);
  assign nwords = 17'(span) * 17'(rh);

  always_comb begin
    res_d = '0;
    case (cmd_i.res_kind)
      RES_FAIL: res_d.status = ST_FAIL;
      RES_BAD:  res_d.status = ST_BAD;
      RES_FULL: begin
        res_d.rect_valid  = 1'b1;
        res_d.rect_last   = 1'b1;
        res_d.full_flag   = 1'b1;
        res_d.rect_width  = 11'(FULL_W);
        res_d.rect_height = 10'(FULL_H);
        res_d.rect_words  = 15'(FULL_N);
      end
      RES_EMPTY: res_d.rect_last = 1'b1;
      RES_RECT, RES_RECT_LAST: begin
        res_d.rect_valid  = 1'b1;
        res_d.rect_x      = {mn_q[4:0], 5'b0};
        res_d.rect_y      = 9'(11'(row_q));
        res_d.rect_width  = {span, 5'b0};
        res_d.rect_height = rh[9:0];
        res_d.rect_words  = nwords[14:0];
        res_d.rect_last   = (cmd_i.res_kind == RES_RECT_LAST);
      end
      default: begin
      end
    endcase
  end

  // outgoing item carries the current generation and failed state
  always_comb begin
    out_d             = res_q;
    out_d.generation  = gen_q;
    out_d.failed_flag = failed_q;
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (cmd_i.take_item) item_q <= in_data_i;
    if (cmd_i.div_calc) prod_q <= 35'(item_q.word_index) * 35'(RECIP);
    if (cmd_i.rowcol_ld) begin
      obs_row_q <= q_fix[RAW-1:0];
      col_q     <= rem_fix[4:0];
    end
    if (cmd_i.mark_ld) begin
      mn_q  <= rd_first;
      mx_q  <= rd_end;
      row_q <= scan_q;
    end
    if (cmd_i.end_ld) end_q <= scan_q;
    if (cmd_i.res_ld) res_q <= res_d;
    if (cmd_i.out_ld) out_q <= out_d;
  end

  // control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      gen_q       <= 64'd1;
      pol_q       <= 1'b0;
      full_q      <= 1'b1;
      failed_q    <= 1'b0;
      cursor_q    <= '0;
      scan_q      <= '0;
      clr_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (cmd_i.gen_inc) gen_q <= gen_q + 64'd1;
      if (cmd_i.set_fail) failed_q <= 1'b1;
      if (cmd_i.pol_ld) pol_q <= item_q.polarity_bit;
      if (cmd_i.full_set) full_q <= 1'b1;
      else if (cmd_i.full_clr) full_q <= 1'b0;
      if (cmd_i.cursor_clr) cursor_q <= '0;
      else if (cmd_i.cursor_ld) cursor_q <= end_q;
      if (cmd_i.scan_from_cursor) scan_q <= cursor_q;
      else if (cmd_i.scan_inc) scan_q <= scan_q + SW'(1);
      if (cmd_i.clr_step) begin
        clr_q <= (clr_q == RAW'(ROWS - 1)) ? '0 : clr_q + RAW'(1);
      end
      if (cmd_i.out_ld) out_valid_q <= 1'b1;
      else if (out_ready_i) out_valid_q <= 1'b0;
    end
  end

  always_comb begin
    sts_o           = '0;
    sts_o.op        = item_q.op;
    sts_o.failed    = failed_q;
    sts_o.full      = full_q;
    sts_o.gen_max   = (gen_q == '1);
    sts_o.in_range  = (17'(item_q.word_index) < 17'(SCREEN));
    sts_o.pol_diff  = (item_q.polarity_bit != pol_q);
    sts_o.mir_diff  = (mir_rdata != item_q.word_value);
    sts_o.row_dirty = (rd_end != '0);
    sts_o.row_match = (rd_first == mn_q) && (rd_end == mx_q);
    sts_o.bad_range = (rd_first >= rd_end) || (7'(rd_end) > 7'(ROW_WORDS));
    sts_o.scan_end  = (scan_q == SW'(ROWS));
    sts_o.clr_last  = (clr_q == RAW'(ROWS - 1));
    sts_o.out_free  = !out_valid_q || out_ready_i;
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

// ----- rtl/dirty_rectangle_tracker.sv -----
// ----------------------------------------------------------------------------
// dirty_rectangle_tracker
// tracks changed framebuffer words per row and hands out merged rectangles
// ----------------------------------------------------------------------------
// One item is worked at a time and every item gives exactly one result
// through an output register, so the next item is taken while a result
// still waits. Loads, polarity checks, unknown ops, refused ops and observed
// words beyond the screen go from dispatch straight to the result; an
// observed word that differs from its mirror passes mirror read,
// reciprocal row split, compare and a row mark read-modify-write on the mark
// memory, and one that matches its mirror stops after the compare. A take
// reads the mark memory once per row it visits, from the cursor through
// the merged rows and on to the next dirty row. Any step that clears the
// marks (polarity change, reinitialize, full refresh, last rectangle, empty
// take) runs a clearing pass over the mark memory before its result; the
// same pass runs after reset, and no item is taken meanwhile.
module dirty_rectangle_tracker #(
  parameter int unsigned ROWS      = 512,
  parameter int unsigned ROW_WORDS = 32
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  drt_pkg::drt_in_t  in_data_i,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output drt_pkg::drt_out_t out_data_o
);
  import drt_pkg::*;

  // command and status between sequencer and datapath
  drt_cmd_t cmd;
  drt_sts_t sts;

  drt_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  // memories, generation counter, flags and result registers
  drt_dp #(
    .ROWS      (ROWS),
    .ROW_WORDS (ROW_WORDS)
  ) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_data_i   (in_data_i),
    .out_ready_i (out_ready_i),
    .out_valid_o (out_valid_o),
    .out_data_o  (out_data_o),
    .cmd_i       (cmd),
    .sts_o       (sts)
  );

endmodule

// ----- rtl/drt_checker.sv -----
// ----------------------------------------------------------------------------
// drt_checker
// port level checks on result items of the tracker
// ----------------------------------------------------------------------------
`include "dirty_rectangle_tracker_defines.svh"

module drt_checker (
  input logic              clk_i,
  input logic              rst_ni,
  input logic              out_valid_o,
  input logic              out_ready_i,
  input drt_pkg::drt_out_t out_data_o
);
  import drt_pkg::*;

  `DRT_ASSERT_NEXT(a_out_hold, out_valid_o && !out_ready_i, out_valid_o && $stable(out_data_o), "stalled result item changed")
  `DRT_ASSERT_NOW(a_rect_ok, out_valid_o && out_data_o.rect_valid, out_data_o.status == ST_OK, "rectangle with error status")
  `DRT_ASSERT_NOW(a_full_last, out_valid_o && out_data_o.full_flag, out_data_o.rect_valid && out_data_o.rect_last, "full refresh not a last rectangle")
  `DRT_ASSERT_NOW(a_fail_flag, out_valid_o && out_data_o.status == ST_FAIL, out_data_o.failed_flag, "refusal without failed flag")

endmodule

bind dirty_rectangle_tracker drt_checker u_drt_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .out_valid_o (out_valid_o),
  .out_ready_i (out_ready_i),
  .out_data_o  (out_data_o)
);

// ----- test/dirty_rectangle_tracker_test.sv -----
// ----------------------------------------------------------------------------
// dirty_rectangle_tracker_test
// self-checking bench: directed and random item streams against an in-bench
// predictor of the tracker, with random idling and a long output hold-off
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module dirty_rectangle_tracker_test;
  import drt_pkg::*;

  localparam int unsigned ROWS      = 512;
  localparam int unsigned ROW_WORDS = 32;
  localparam int unsigned SCREEN    = ROWS * ROW_WORDS;
  localparam int unsigned LIMIT     = 4000000;
  localparam logic [2:0]  OP_SPARE  = 3'd5;   // first of the unused op codes

  logic     clk_i = 1'b0;
  logic     rst_ni = 1'b0;
  logic     in_valid_i = 1'b0;
  logic     in_ready_o;
  drt_in_t  in_data_i = '0;
  logic     out_valid_o;
  logic     out_ready_i = 1'b0;
  drt_out_t out_data_o;

  always #10 clk_i = ~clk_i;

  dirty_rectangle_tracker #(.ROWS(ROWS), .ROW_WORDS(ROW_WORDS)) dut (
    .clk_i, .rst_ni, .in_valid_i, .in_ready_o, .in_data_i,
    .out_valid_o, .out_ready_i, .out_data_o
  );

  // shadow copy of the tracker state
  logic [31:0] mirror_shadow [SCREEN];
  bit          mirror_loaded [SCREEN];
  int          loaded_idx_q[$];
  logic [5:0]  first_dirty [ROWS];
  logic [5:0]  end_dirty [ROWS];
  logic [63:0] gen_shadow;
  logic        pol_shadow;
  logic        full_shadow;
  logic        failed_shadow;
  int          cursor_shadow;

  drt_out_t    expected_rects_q[$];
  int          mismatches = 0;
  bit          idle_on = 1'b1;
  int          hold_left = 0;
  bit          long_hold = 1'b0;
  event        stall_ev;
  int unsigned cycles = 0;

  // ---------------------------------------------------------------- predictor
  function automatic void clear_rows();
    for (int r = 0; r < ROWS; r++) begin
      first_dirty[r] = '0;
      end_dirty[r] = '0;
    end
  endfunction

  function automatic int next_dirty_row(int r);
    while (r < ROWS && end_dirty[r] == 0) r++;
    return r;
  endfunction

  function automatic drt_out_t tracker_step(drt_in_t it);
    drt_out_t res;
    int row, col, stop;
    logic [5:0] lo, hi;
    res = '0;
    if (it.op == OP_LOAD) begin
      mirror_shadow[it.word_index] = it.word_value;
    end else if (it.op <= OP_INIT && failed_shadow) begin
      res.status = ST_FAIL;
    end else if (it.op == OP_WORD) begin
      if (mirror_shadow[it.word_index] != it.word_value) begin
        if (gen_shadow == '1) begin
          failed_shadow = 1'b1;
          res.status = ST_FAIL;
        end else begin
          mirror_shadow[it.word_index] = it.word_value;
          row = int'(it.word_index) / ROW_WORDS;
          col = int'(it.word_index) % ROW_WORDS;
          if (end_dirty[row] == 0 || col < first_dirty[row]) first_dirty[row] = 6'(col);
          if (col + 1 > end_dirty[row]) end_dirty[row] = 6'(col + 1);
          gen_shadow++;
        end
      end
    end else if (it.op == OP_POL) begin
      if (it.polarity_bit != pol_shadow) begin
        if (gen_shadow == '1) begin
          failed_shadow = 1'b1;
          res.status = ST_FAIL;
        end else begin
          pol_shadow = it.polarity_bit;
          full_shadow = 1'b1;
          clear_rows();
          gen_shadow++;
        end
      end
    end else if (it.op == OP_INIT) begin
      if (gen_shadow == '1) begin
        failed_shadow = 1'b1;
        res.status = ST_FAIL;
      end else begin
        gen_shadow++;
        clear_rows();
        pol_shadow = it.polarity_bit;
        full_shadow = 1'b1;
        cursor_shadow = 0;
      end
    end else if (it.op == OP_TAKE) begin
      if (full_shadow) begin
        res.rect_valid = 1'b1;
        res.rect_last = 1'b1;
        res.full_flag = 1'b1;
        res.rect_width = 11'(ROW_WORDS * 32);
        res.rect_height = 10'(ROWS);
        res.rect_words = 15'(SCREEN);
        full_shadow = 1'b0;
        clear_rows();
        cursor_shadow = 0;
      end else begin
        row = next_dirty_row(cursor_shadow);
        if (row >= ROWS) begin
          res.rect_last = 1'b1;
          clear_rows();
          cursor_shadow = 0;
        end else begin
          lo = first_dirty[row];
          hi = end_dirty[row];
          stop = row + 1;
          while (stop < ROWS && end_dirty[stop] != 0 &&
                 first_dirty[stop] == lo && end_dirty[stop] == hi) stop++;
          if (lo >= hi || hi > ROW_WORDS) begin
            res.status = ST_BAD;
            cursor_shadow = 0;
          end else begin
            res.rect_valid = 1'b1;
            res.rect_x = 10'(int'(lo) * 32);
            res.rect_y = 9'(row);
            res.rect_width = 11'((int'(hi) - int'(lo)) * 32);
            res.rect_height = 10'(stop - row);
            res.rect_words = 15'((int'(hi) - int'(lo)) * (stop - row));
            if (next_dirty_row(stop) >= ROWS) begin
              res.rect_last = 1'b1;
              clear_rows();
              cursor_shadow = 0;
            end else begin
              cursor_shadow = stop;
            end
          end
        end
      end
    end
    res.generation = gen_shadow;
    res.failed_flag = failed_shadow;
    return res;
  endfunction

  // ------------------------------------------------------------------ sender
  // drives one item, waits for its handshake and records what it must give
  task automatic send_item(input drt_in_t it, output drt_out_t res);
    int gap;
    if (idle_on && $urandom_range(0, 3) == 0) begin
      gap = $urandom_range(1, 3);
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i <= it;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    if (it.op == OP_LOAD && !mirror_loaded[it.word_index]) begin
      mirror_loaded[it.word_index] = 1'b1;
      loaded_idx_q.push_back(int'(it.word_index));
    end
    res = tracker_step(it);
    expected_rects_q.push_back(res);
  endtask

  task automatic send_op(logic [2:0] op, int idx, logic [31:0] val, logic pol);
    drt_in_t it;
    drt_out_t res;
    it.op = op;
    it.word_index = 14'(idx);
    it.word_value = val;
    it.polarity_bit = pol;
    send_item(it, res);
  endtask

  // load a word, then observe a value that differs from it most of the time
  task automatic touch_word(int idx);
    logic [31:0] v;
    v = $urandom();
    send_op(OP_LOAD, idx, v, 1'($urandom_range(0, 1)));
    send_op(OP_WORD, idx, ($urandom_range(0, 7) == 0) ? v : ~v, 1'($urandom_range(0, 1)));
  endtask

  // keep taking until the sequence reports its last rectangle or an error status
  task automatic drain_takes();
    drt_in_t it;
    drt_out_t res;
    it = '0;
    it.op = OP_TAKE;
    do begin
      it.word_index = 14'($urandom());
      it.word_value = $urandom();
      send_item(it, res);
    end while (!res.rect_last && res.status == ST_OK);
  endtask

  // ---------------------------------------------------------------- receiver
  always @(posedge clk_i) begin
    if (long_hold) begin
      out_ready_i <= 1'b0;
    end else if (hold_left > 0) begin
      out_ready_i <= 1'b0;
      hold_left <= hold_left - 1;
    end else if (idle_on && $urandom_range(0, 4) == 0) begin
      out_ready_i <= 1'b0;
      hold_left <= $urandom_range(0, 2);
    end else begin
      out_ready_i <= 1'b1;
    end
  end

  // long receiver hold-off, counted here
  always begin
    @(stall_ev);
    long_hold <= 1'b1;
    repeat (300) @(posedge clk_i);
    long_hold <= 1'b0;
  end

  // compare each result with the oldest expectation
  always @(posedge clk_i) begin
    drt_out_t want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (expected_rects_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result %p", out_data_o);
      end else begin
        want = expected_rects_q.pop_front();
        if (out_data_o.status !== want.status || out_data_o.rect_valid !== want.rect_valid ||
            out_data_o.rect_x !== want.rect_x || out_data_o.rect_y !== want.rect_y ||
            out_data_o.rect_width !== want.rect_width ||
            out_data_o.rect_height !== want.rect_height ||
            out_data_o.rect_words !== want.rect_words ||
            out_data_o.rect_last !== want.rect_last ||
            out_data_o.full_flag !== want.full_flag ||
            out_data_o.generation !== want.generation ||
            out_data_o.failed_flag !== want.failed_flag) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch: expected %p actual %p", want, out_data_o);
        end
      end
    end
  end

  // watchdog
  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > LIMIT) begin
      $display("** dirty_rectangle_tracker: FAILED **");
      $finish;
    end
  end

  // ------------------------------------------------------------------ tests
  task automatic test_directed();
    send_op(OP_TAKE, 0, 0, 0);                 // full refresh after reset
    send_op(OP_TAKE, 0, 0, 0);                 // empty take
    send_op(OP_LOAD, 0, 32'h0, 0);
    send_op(OP_WORD, 0, 32'h0, 0);             // same word, no mark
    send_op(OP_WORD, 0, 32'hFFFF_FFFF, 0);     // row 0 col 0
    send_op(OP_LOAD, SCREEN - 1, 32'hFFFF_FFFF, 1);
    send_op(OP_WORD, SCREEN - 1, 32'h0, 1);    // last row, last column
    for (int r = 10; r < 13; r++) begin        // three rows with equal ranges merge
      touch_word(r * ROW_WORDS + 3);
      send_op(OP_LOAD, r * ROW_WORDS + 7, 32'h1234_5678, 0);
      send_op(OP_WORD, r * ROW_WORDS + 7, 32'h8765_4321, 0);
    end
    drain_takes();
    send_op(OP_TAKE, 16'h3FFF, '1, 1);         // empty again
    send_op(OP_POL, 0, 0, 1);                  // polarity change forces full
    send_op(OP_POL, 0, 0, 1);                  // unchanged polarity
    send_op(OP_TAKE, 0, 0, 0);
    send_op(OP_INIT, '1, '1, 0);
    send_op(OP_TAKE, 0, 0, 0);
    for (int k = 0; k < 3; k++) send_op(OP_SPARE + 3'(k), '1, '1, 1);
  endtask

  // well-formed mark/take sequences with random content, plus noise
  task automatic test_random(int n_seq);
    int base, rows, lo, hi, idx;
    for (int s = 0; s < n_seq; s++) begin
      base = $urandom_range(0, ROWS - 1);
      rows = $urandom_range(1, 4);
      lo = $urandom_range(0, ROW_WORDS - 1);
      hi = $urandom_range(lo, ROW_WORDS - 1);
      for (int r = base; r < base + rows && r < ROWS; r++) begin
        touch_word(r * ROW_WORDS + lo);
        if (hi != lo && $urandom_range(0, 3) != 0) touch_word(r * ROW_WORDS + hi);
      end
      if ($urandom_range(0, 3) == 0) begin
        // noise: random op, observes only on words already loaded
        idx = loaded_idx_q[$urandom_range(0, loaded_idx_q.size() - 1)];
        case ($urandom_range(0, 4))
          0: send_op(OP_WORD, idx, $urandom(), 1'($urandom_range(0, 1)));
          1: send_op(OP_POL, $urandom(), $urandom(), 1'($urandom_range(0, 1)));
          2: send_op(OP_INIT, $urandom(), $urandom(), 1'($urandom_range(0, 1)));
          3: send_op(OP_TAKE, $urandom(), $urandom(), 1'($urandom_range(0, 1)));
          default: send_op(3'($urandom_range(5, 7)), $urandom(), $urandom(), 1);
        endcase
      end
      if ($urandom_range(0, 2) == 0) drain_takes();
    end
    drain_takes();
  endtask

  // receiver holds off while items keep coming, so the block backs up
  task automatic test_backpressure();
    @(posedge clk_i);
    -> stall_ev;
    for (int k = 0; k < 10; k++) touch_word($urandom_range(0, SCREEN - 1));
    drain_takes();
  endtask

  initial begin
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    for (int i = 0; i < SCREEN; i++) mirror_shadow[i] = '0;
    clear_rows();
    gen_shadow = 64'd1;
    pol_shadow = 1'b0;
    full_shadow = 1'b1;
    failed_shadow = 1'b0;
    cursor_shadow = 0;
    test_directed();
    test_random(50);
    test_backpressure();
    idle_on = 1'b0;                            // no idling in the last part
    test_random(15);
    @(posedge clk_i);
    in_valid_i <= 1'b0;
    while (expected_rects_q.size() != 0) @(posedge clk_i);
    repeat (1200) @(posedge clk_i);
    if (mismatches == 0 && expected_rects_q.size() == 0) begin
      $display("** dirty_rectangle_tracker: PASSED **");
    end else begin
      $display("** dirty_rectangle_tracker: FAILED **");
    end
    $finish;
  end

endmodule
